>>> hw/rtl/modular_exponentiation_defines.svh
// Assertion macros used by the modular exponentiation checker.
`ifndef MODULAR_EXPONENTIATION_DEFINES_SVH
`define MODULAR_EXPONENTIATION_DEFINES_SVH

// Clocked assertion, quiet while reset is asserted.
`define MEX_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also checks across reset.
`define MEX_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/mex_pkg.sv
// Package: configuration register codes and reset values for modular exponentiation.
`timescale 1ns / 1ps
`default_nettype none

package mex_pkg;

    localparam int CFG_IDX_W = 1;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx REG_EXPONENT = 1'b0;
    localparam t_cfg_idx REG_MODULUS  = 1'b1;

    localparam logic [63:0] EXP_RESET = 64'd65537;
    localparam logic [63:0] MOD_RESET = 64'd1;

endpackage

`default_nettype wire

>>> hw/rtl/modular_exponentiation.sv
// Top level: modular exponentiation by right-to-left square-and-multiply.
`timescale 1ns / 1ps
`default_nettype none

// Raises each item's value to the configured exponent modulo the configured
// modulus. All arithmetic runs through one shift-add modular multiplier that
// retires one multiplier bit per cycle. An item first passes once through
// that unit to reduce the base. Then, for an exponent whose highest set bit
// is at position L-1, it takes one multiply per set bit and L-1 squarings.
// On top of that, every exponent bit passes through a decision state, a
// further decision sees the exponent run out, the output register is loaded
// and the block goes back to idle before the next item is taken. A result
// held by the downstream side keeps the block waiting once the next result
// is ready.
// An exponent of zero gives 1 for every modulus; a modulus of zero acts as
// one. The input stall stays high from acceptance until the result has been
// placed in the output register; a new item may enter while that result
// still waits for the downstream side. Write exponent and modulus only while
// the block is idle.
module modular_exponentiation #(
    parameter int WORD_BITS = 60
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // configuration write port
    input  wire logic                  i_cfg_we,
    input  wire mex_pkg::t_cfg_idx     i_cfg_idx,
    input  wire logic [WORD_BITS-1:0]  i_cfg_data,
    // input item channel
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic [WORD_BITS-1:0]  i_value_in,
    // result item channel
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic [WORD_BITS-1:0]       o_value_out
);
    import mex_pkg::*;

    localparam int CNT_W = $clog2(WORD_BITS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WORD_BITS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_REDUCE,
        S_BIT,
        S_MUL,
        S_SQR,
        S_DONE
    } t_state;

    // sequencer and configuration
    t_state               r_state, n_state;
    logic [WORD_BITS-1:0] r_exp, n_exp;
    logic [WORD_BITS-1:0] r_mod, n_mod;
    // per-item working registers
    logic [WORD_BITS-1:0] r_m, n_m;
    logic [WORD_BITS-1:0] r_e, n_e;
    logic [WORD_BITS-1:0] r_res, n_res;
    logic [WORD_BITS-1:0] r_cur, n_cur;
    // shared multiplier: accumulator, addend, multiplier bits, step count
    logic [WORD_BITS-1:0] r_acc, n_acc;
    logic [WORD_BITS-1:0] r_ma, n_ma;
    logic [WORD_BITS-1:0] r_mb, n_mb;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    // output register
    logic                 r_out_valid, n_out_valid;
    logic [WORD_BITS-1:0] r_out, n_out;

    // One multiplier step: double and reduce, then add the addend on a set
    // multiplier bit and reduce again. The accumulator always stays below m.
    logic [WORD_BITS:0]   m_ext;
    logic [WORD_BITS:0]   dbl, dbl_red, sum, sum_red;
    logic [WORD_BITS-1:0] step_val;
    logic                 last_step;

    assign m_ext     = {1'b0, r_m};
    assign dbl       = {r_acc, 1'b0};
    assign dbl_red   = (dbl >= m_ext) ? (dbl - m_ext) : dbl;
    assign sum       = dbl_red + (r_mb[WORD_BITS-1] ? {1'b0, r_ma} : '0);
    assign sum_red   = (sum >= m_ext) ? (sum - m_ext) : sum;
    assign step_val  = sum_red[WORD_BITS-1:0];
    assign last_step = (r_cnt == '0);

    always_comb begin
        n_state     = r_state;
        n_exp       = r_exp;
        n_mod       = r_mod;
        n_m         = r_m;
        n_e         = r_e;
        n_res       = r_res;
        n_cur       = r_cur;
        n_acc       = r_acc;
        n_ma        = r_ma;
        n_mb        = r_mb;
        n_cnt       = r_cnt;
        n_out       = r_out;
        // drop the held result once the downstream side takes it
        n_out_valid = r_out_valid && i_out_stall;

        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_EXPONENT: n_exp = i_cfg_data;
                REG_MODULUS:  n_mod = i_cfg_data;
                default:      ;
            endcase
        end

        // advance the shared multiplier in every product state
        if (r_state == S_REDUCE || r_state == S_MUL || r_state == S_SQR) begin
            n_acc = step_val;
            n_mb  = {r_mb[WORD_BITS-2:0], 1'b0};
            n_cnt = last_step ? r_cnt : (r_cnt - 1'b1);
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    // reduce the base first: 1 * value mod m
                    n_m     = (r_mod == '0) ? WORD_BITS'(1) : r_mod;
                    n_e     = r_exp;
                    n_res   = WORD_BITS'(1);
                    n_acc   = '0;
                    n_ma    = WORD_BITS'(1);
                    n_mb    = i_value_in;
                    n_cnt   = CNT_LAST;
                    n_state = S_REDUCE;
                end
            end
            S_REDUCE: begin
                if (last_step) begin
                    n_cur   = step_val;
                    n_state = S_BIT;
                end
            end
            S_BIT: begin
                n_acc = '0;
                n_cnt = CNT_LAST;
                n_ma  = r_cur;
                if (r_e == '0) begin
                    n_state = S_DONE;
                end else if (r_e[0]) begin
                    n_mb    = r_res;
                    n_state = S_MUL;
                end else begin
                    n_mb    = r_cur;
                    n_state = S_SQR;
                end
            end
            S_MUL: begin
                if (last_step) begin
                    n_res = step_val;
                    if (r_e[WORD_BITS-1:1] == '0) begin
                        // no higher bit: skip the final squaring
                        n_e     = r_e >> 1;
                        n_state = S_BIT;
                    end else begin
                        n_acc   = '0;
                        n_cnt   = CNT_LAST;
                        n_ma    = r_cur;
                        n_mb    = r_cur;
                        n_state = S_SQR;
                    end
                end
            end
            S_SQR: begin
                if (last_step) begin
                    n_cur   = step_val;
                    n_e     = r_e >> 1;
                    n_state = S_BIT;
                end
            end
            S_DONE: begin
                // hold until the output register is free or being emptied
                if (!r_out_valid || !i_out_stall) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_exp       <= WORD_BITS'(EXP_RESET);
            r_mod       <= WORD_BITS'(MOD_RESET);
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_exp       <= n_exp;
            r_mod       <= n_mod;
        end
        r_m   <= n_m;
        r_e   <= n_e;
        r_res <= n_res;
        r_cur <= n_cur;
        r_acc <= n_acc;
        r_ma  <= n_ma;
        r_mb  <= n_mb;
        r_cnt <= n_cnt;
        r_out <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_value_out = r_out;

endmodule

`default_nettype wire

>>> hw/rtl/mex_checker.sv
// Port-level checker for modular exponentiation, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "modular_exponentiation_defines.svh"

module mex_checker #(
    parameter int WORD_BITS = 60
) (
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 i_in_valid,
    input wire logic                 o_in_stall,
    input wire logic                 o_out_valid,
    input wire logic                 i_out_stall,
    input wire logic [WORD_BITS-1:0] o_value_out
);

    `MEX_ASSERT_RST(a_reset_clears, i_clk, !i_rst_n |=> (!o_out_valid && !o_in_stall), "reset left block busy or result valid")
    `MEX_ASSERT(a_busy_after_accept, i_clk, i_rst_n, (i_in_valid && !o_in_stall) |=> o_in_stall, "block not busy after taking an item")
    `MEX_ASSERT(a_result_from_busy, i_clk, i_rst_n, $rose(o_out_valid) |-> $past(o_in_stall), "result appeared without an item in work")
    `MEX_ASSERT(a_held_result, i_clk, i_rst_n, (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_value_out)), "stalled result dropped or changed")

endmodule

bind modular_exponentiation mex_checker #(.WORD_BITS(WORD_BITS)) u_mex_checker (.*);

`default_nettype wire
